FILE: rtl/hu8_pkg.sv
// ----------------------------------------------------------------------------
// hu8_pkg
// Shared types and constants for the hex UCS-2 to UTF-8 decoder.
// ----------------------------------------------------------------------------
package hu8_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [15:0] UnitOneByteLim = 16'h0080;
  localparam logic [15:0] UnitTwoByteLim = 16'h0800;
  localparam logic [15:0] UnitStop       = 16'hFFFF;
  localparam logic [7:0]  LeadTwo        = 8'hC0;
  localparam logic [7:0]  LeadThree      = 8'hE0;
  localparam logic [7:0]  ContMark       = 8'h80;
  localparam logic [5:0]  ContMask       = 6'h3F;

  // Work handed from front to back: 1..3 bytes, or a bare end marker (cnt 0)
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       text_end;
  } cmd_t;

endpackage

FILE: rtl/hex_ucs2_to_utf8_decoder_top.sv
// ----------------------------------------------------------------------------
// hex_ucs2_to_utf8_decoder_top
// Converts a stream of ASCII hex characters (UCS-2, four per unit) to UTF-8.
// ----------------------------------------------------------------------------
// Input channel: one hex character per transfer, last_char_i marks the end
// of a text. Output channel: one UTF-8 byte per transfer with last_of_run
// on the final byte of a unit and text_end on the final result of a text;
// a text whose final character yields no byte ends in a bare marker with
// byte_valid low.
// Throughput: one character per cycle while the queue is not full. The front
// decodes each character in the cycle it arrives and, on a fourth character
// whose unit yields bytes or on the final one, writes a command into a
// QueueDepth-entry queue. The back drains one byte per cycle while the
// receiver does not stall. The bytes of a unit pass through the queue write
// and then the back register before they appear.
// When the receiver stalls, the current result holds and the queue fills;
// the input stalls only once the queue is full.
// Reset clears the decode state, the queue and the output valid; the block
// is ready for input as soon as reset is released.
// ----------------------------------------------------------------------------
module hex_ucs2_to_utf8_decoder_top #(
  parameter int unsigned QueueDepth = hu8_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] hex_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] utf8_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_run_o,
  output logic       text_end_o
);

  logic          push, full, pop, q_valid;
  hu8_pkg::cmd_t push_cmd, pop_cmd;

  hu8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hex_char_i  (hex_char_i),
    .last_char_i (last_char_i),
    .cmd_valid_o (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full)
  );

  hu8_fifo #(
    .QueueDepth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  hu8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .utf8_byte_o   (utf8_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .text_end_o    (text_end_o)
  );

endmodule

FILE: rtl/hu8_front.sv
// ----------------------------------------------------------------------------
// hu8_front
// Gathers hex characters into UCS-2 units and turns each unit into a
// command holding its UTF-8 bytes.
// ----------------------------------------------------------------------------
module hu8_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    hex_char_i,
  input  logic          last_char_i,
  output logic          cmd_valid_o,
  output hu8_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);

  logic [11:0] unit_accum_q, unit_accum_d;
  logic [1:0]  char_phase_q, char_phase_d;
  logic        pair_bad_q, pair_bad_d;
  logic        high_bad_q, high_bad_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [3:0]  nib;
  logic        bad;
  logic [7:0]  hi_byte, lo_byte;
  logic [15:0] unit;
  logic [1:0]  n_bytes;
  logic        produce;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i & ~cmd_full_i;

  // Hex digit decode
  always_comb begin
    bad = 1'b0;
    nib = 4'h0;
    if (hex_char_i >= 8'h30 && hex_char_i <= 8'h39) begin
      nib = hex_char_i[3:0];
    end else if ((hex_char_i >= 8'h61 && hex_char_i <= 8'h66) ||
                 (hex_char_i >= 8'h41 && hex_char_i <= 8'h46)) begin
      nib = hex_char_i[3:0] + 4'd9;
    end else begin
      bad = 1'b1;
    end
  end

  assign hi_byte = high_bad_q ? 8'h00 : unit_accum_q[11:4];
  assign lo_byte = (pair_bad_q | bad) ? 8'h00 : {unit_accum_q[3:0], nib};
  assign unit    = {hi_byte, lo_byte};
  assign produce = ~halted_q & (char_phase_q == 2'd3);

  // Classify the unit and build its bytes
  always_comb begin
    cmd_o = '0;
    if (!produce || unit == 16'h0000 || unit == hu8_pkg::UnitStop) begin
      n_bytes = 2'd0;
    end else if (unit < hu8_pkg::UnitOneByteLim) begin
      n_bytes  = 2'd1;
      cmd_o.b0 = unit[7:0];
    end else if (unit < hu8_pkg::UnitTwoByteLim) begin
      n_bytes  = 2'd2;
      cmd_o.b0 = hu8_pkg::LeadTwo | {3'b000, unit[10:6]};
      cmd_o.b1 = hu8_pkg::ContMark | {2'b00, unit[5:0] & hu8_pkg::ContMask};
    end else begin
      n_bytes  = 2'd3;
      cmd_o.b0 = hu8_pkg::LeadThree | {4'h0, unit[15:12]};
      cmd_o.b1 = hu8_pkg::ContMark | {2'b00, unit[11:6]};
      cmd_o.b2 = hu8_pkg::ContMark | {2'b00, unit[5:0] & hu8_pkg::ContMask};
    end
    cmd_o.cnt      = n_bytes;
    cmd_o.text_end = last_char_i;
  end

  assign cmd_valid_o = accept & ((n_bytes != 2'd0) | last_char_i);

  always_comb begin
    unit_accum_d = unit_accum_q;
    char_phase_d = char_phase_q;
    pair_bad_d   = pair_bad_q;
    high_bad_d   = high_bad_q;
    halted_d     = halted_q;
    if (accept) begin
      if (last_char_i) begin
        // text end: start the next text clean
        unit_accum_d = '0;
        char_phase_d = '0;
        pair_bad_d   = 1'b0;
        high_bad_d   = 1'b0;
        halted_d     = 1'b0;
      end else if (!halted_q) begin
        unique case (char_phase_q)
          2'd0: begin
            unit_accum_d = {8'h00, nib};
            pair_bad_d   = bad;
            char_phase_d = 2'd1;
          end
          2'd1: begin
            unit_accum_d = {unit_accum_q[7:0], nib};
            high_bad_d   = pair_bad_q | bad;
            pair_bad_d   = 1'b0;
            char_phase_d = 2'd2;
          end
          2'd2: begin
            unit_accum_d = {unit_accum_q[7:0], nib};
            pair_bad_d   = bad;
            char_phase_d = 2'd3;
          end
          default: begin
            halted_d     = (n_bytes == 2'd0);
            unit_accum_d = '0;
            pair_bad_d   = 1'b0;
            high_bad_d   = 1'b0;
            char_phase_d = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_accum_q <= '0;
      char_phase_q <= '0;
      pair_bad_q   <= 1'b0;
      high_bad_q   <= 1'b0;
      halted_q     <= 1'b0;
    end else begin
      unit_accum_q <= unit_accum_d;
      char_phase_q <= char_phase_d;
      pair_bad_q   <= pair_bad_d;
      high_bad_q   <= high_bad_d;
      halted_q     <= halted_d;
    end
  end

endmodule

FILE: rtl/hu8_fifo.sv
// ----------------------------------------------------------------------------
// hu8_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hu8_fifo #(
  parameter int unsigned QueueDepth = hu8_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hu8_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hu8_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  hu8_pkg::cmd_t       slots_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/hu8_back.sv
// ----------------------------------------------------------------------------
// hu8_back
// Plays out each queued command as one output transfer per byte, or one
// bare end marker.
// ----------------------------------------------------------------------------
module hu8_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  hu8_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    utf8_byte_o,
  output logic          byte_valid_o,
  output logic          last_of_run_o,
  output logic          text_end_o
);

  hu8_pkg::cmd_t cur_q, cur_d;
  logic          busy_q, busy_d;
  logic [1:0]    idx_q, idx_d;
  logic          take, fin;

  assign fin  = (cur_q.cnt == 2'd0) || (idx_q == cur_q.cnt - 2'd1);
  assign take = busy_q & ~out_stall_i;
  assign cmd_pop_o = cmd_valid_i & (~busy_q | (take & fin));

  assign out_valid_o   = busy_q;
  assign byte_valid_o  = (cur_q.cnt != 2'd0);
  assign last_of_run_o = fin;
  assign text_end_o    = fin & cur_q.text_end;

  always_comb begin
    unique case (idx_q)
      2'd0:    utf8_byte_o = byte_valid_o ? cur_q.b0 : 8'h00;
      2'd1:    utf8_byte_o = cur_q.b1;
      default: utf8_byte_o = cur_q.b2;
    endcase
  end

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (cmd_pop_o) begin
      // load the next command as soon as the current one is done
      cur_d  = cmd_i;
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (take) begin
      if (fin) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

FILE: tb/utf8_stream_checker.sv
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches both channels of the hex UCS-2 to UTF-8 decoder, predicts the
// UTF-8 bytes that each accepted character causes and compares every
// accepted output transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] hex_char_i,
  input  logic       last_char_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] utf8_byte_i,
  input  logic       byte_valid_i,
  input  logic       last_of_run_i,
  input  logic       text_end_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] octet;
    logic       has_byte;
    logic       run_end;
    logic       text_done;
  } utf8_res_t;

  utf8_res_t   utf8_expected_q[$];
  int          mismatches;

  // Decode state of the predicted block
  logic [11:0] accum;
  logic [1:0]  phase;
  logic        pair_bad;
  logic        hi_bad;
  logic        halted;

  // Bit 4 set for a non-hex character, else the digit value
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      return 5'h10;
    end
    return {1'b0, d[3:0]};
  endfunction

  task automatic predict_char(input logic [7:0] c, input logic fin);
    logic [4:0]  dv;
    logic        bad;
    logic [3:0]  nib;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] unit;
    logic [7:0]  b [3];
    utf8_res_t   res;
    int          n;
    n = 0;
    if (!halted) begin
      dv  = digit_of(c);
      bad = dv[4];
      nib = dv[3:0];
      case (phase)
        2'd0: begin
          accum    = {8'h00, nib};
          pair_bad = bad;
          phase    = 2'd1;
        end
        2'd1: begin
          accum    = {accum[7:0], nib};
          hi_bad   = pair_bad | bad;
          pair_bad = 1'b0;
          phase    = 2'd2;
        end
        2'd2: begin
          accum    = {accum[7:0], nib};
          pair_bad = bad;
          phase    = 2'd3;
        end
        default: begin
          hi   = hi_bad ? 8'h00 : accum[11:4];
          lo   = (pair_bad | bad) ? 8'h00 : {accum[3:0], nib};
          unit = {hi, lo};
          if (unit == 16'h0000 || unit == hu8_pkg::UnitStop) begin
            halted = 1'b1;
          end else if (unit < hu8_pkg::UnitOneByteLim) begin
            b[0] = unit[7:0];
            n = 1;
          end else if (unit < hu8_pkg::UnitTwoByteLim) begin
            b[0] = hu8_pkg::LeadTwo | {3'b000, unit[10:6]};
            b[1] = hu8_pkg::ContMark | {2'b00, unit[5:0]};
            n = 2;
          end else begin
            b[0] = hu8_pkg::LeadThree | {4'h0, unit[15:12]};
            b[1] = hu8_pkg::ContMark | {2'b00, unit[11:6]};
            b[2] = hu8_pkg::ContMark | {2'b00, unit[5:0]};
            n = 3;
          end
          accum    = 12'h000;
          pair_bad = 1'b0;
          hi_bad   = 1'b0;
          phase    = 2'd0;
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      res = '{b[k], 1'b1, k == n - 1, (k == n - 1) && fin};
      utf8_expected_q = {utf8_expected_q, res};
    end
    if (fin) begin
      // a text that ends without a byte still closes with a bare marker
      if (n == 0) begin
        res = '{8'h00, 1'b0, 1'b1, 1'b1};
        utf8_expected_q = {utf8_expected_q, res};
      end
      accum    = 12'h000;
      phase    = 2'd0;
      pair_bad = 1'b0;
      hi_bad   = 1'b0;
      halted   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8_res_t want;
    if (!rst_ni) begin
      accum    = 12'h000;
      phase    = 2'd0;
      pair_bad = 1'b0;
      hi_bad   = 1'b0;
      halted   = 1'b0;
      mismatches = 0;
      utf8_expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (utf8_expected_q.size() == 0) begin
          $error("unexpected result transfer: utf8_byte %0h byte_valid %0b",
                 utf8_byte_i, byte_valid_i);
          mismatches++;
        end else begin
          want = utf8_expected_q.pop_front();
          if (utf8_byte_i !== want.octet) begin
            $error("utf8_byte: expected %0h, got %0h", want.octet, utf8_byte_i);
            mismatches++;
          end
          if (byte_valid_i !== want.has_byte) begin
            $error("byte_valid: expected %0b, got %0b", want.has_byte, byte_valid_i);
            mismatches++;
          end
          if (last_of_run_i !== want.run_end) begin
            $error("last_of_run: expected %0b, got %0b", want.run_end, last_of_run_i);
            mismatches++;
          end
          if (text_end_i !== want.text_done) begin
            $error("text_end: expected %0b, got %0b", want.text_done, text_end_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_char(hex_char_i, last_char_i);
    end
    fail_count_o = mismatches;
    pending_o    = utf8_expected_q.size();
  end

endmodule

FILE: tb/hex_ucs2_to_utf8_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// hex_ucs2_to_utf8_decoder_top_tb
// Feeds the decoder directed texts (unit sizes, surrogates, non-hex pairs,
// stop units, leftovers) and then random texts, mostly well-formed hex with
// random units plus noise, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module hex_ucs2_to_utf8_decoder_top_tb;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] hex_char_i = 8'h00;
  logic       last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] utf8_byte_o;
  logic       byte_valid_o;
  logic       last_of_run_o;
  logic       text_end_o;

  int         fail_count;
  int         pending;
  int         chars_sent = 0;
  logic       calm = 1'b0;
  logic       in_took = 1'b0;
  logic [7:0] text_q[$];

  hex_ucs2_to_utf8_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hex_char_i   (hex_char_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .utf8_byte_o  (utf8_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_of_run_o(last_of_run_o),
    .text_end_o   (text_end_o)
  );

  utf8_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .hex_char_i   (hex_char_i),
    .last_char_i  (last_char_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .utf8_byte_i  (utf8_byte_o),
    .byte_valid_i (byte_valid_o),
    .last_of_run_i(last_of_run_o),
    .text_end_i   (text_end_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Remember whether the input transfer happened at this edge
  always @(posedge clk_i) in_took <= in_valid_i && !in_stall_o;

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 37);

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  task automatic add_char(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s.getc(i));
  endtask

  task automatic add_unit(input logic [15:0] u);
    for (int i = 3; i >= 0; i--) add_char(hex_ascii(u[i*4 +: 4]));
  endtask

  // Enter and leave at a falling edge
  task automatic push_char(input logic [7:0] c, input logic fin);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    hex_char_i  <= c;
    last_char_i <= fin;
    do @(negedge clk_i); while (!in_took);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) push_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic make_text();
    logic [15:0] u;
    int          kind;
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(6, 1)) begin
        kind = $urandom_range(99);
        if (kind < 25) begin
          u = 16'($urandom_range(16'h007F, 16'h0001));
        end else if (kind < 45) begin
          u = 16'($urandom_range(16'h07FF, 16'h0080));
        end else if (kind < 70) begin
          u = 16'($urandom_range(16'hFFFE, 16'h0800));
        end else if (kind < 80) begin
          u = 16'($urandom_range(16'hDFFF, 16'hD800));
        end else if (kind < 92) begin
          case ($urandom_range(5))
            0: u = 16'h0001;
            1: u = 16'h007F;
            2: u = 16'h0080;
            3: u = 16'h07FF;
            4: u = 16'h0800;
            default: u = 16'hFFFE;
          endcase
        end else if (kind < 96) begin
          u = hu8_pkg::UnitStop;
        end else begin
          u = 16'h0000;
        end
        add_unit(u);
      end
      // trailing partial group
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) add_char(hex_ascii(4'($urandom_range(15))));
      end
      // corrupt one character now and then
      if ($urandom_range(9) == 0) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(9, 1)) add_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one-byte unit closing the text
    add_str("0041");
    send_text();
    // surrogate in mixed case, then a dropped partial group
    add_str("D83d7f");
    send_text();
    // non-hex high pair, stop unit, ignored characters up to a bare marker
    add_char(8'h00);
    add_str("0a5ffFf1");
    add_char(8'hFF);
    send_text();
    // zero unit on the final character
    add_str("0000");
    send_text();

    while (chars_sent < 350) begin
      calm = (chars_sent >= 120 && chars_sent < 200);
      if (!paused && chars_sent >= 220) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      make_text();
      send_text();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
